// ===== hw/rtl/ttw_pkg.sv =====
// shared types, codes and constants of the text terminal writer
`timescale 1ns / 1ps
package ttw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int KIND_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int WORD_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int CFG_INDEX_W = 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [COLOR_W-1:0]     data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/ttw_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface ttw_req_if;
  import ttw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [CHAR_W-1:0]      char_code;
  logic [ROW_FIELD_W-1:0] read_row;
  logic [COL_FIELD_W-1:0] read_col;

  modport source (output valid, kind, char_code, read_row, read_col, input ready);
  modport sink (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface ttw_rsp_if;
  import ttw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WORD_W-1:0]      cell_word;
  logic [ROW_FIELD_W-1:0] cursor_row;
  logic [COL_FIELD_W-1:0] cursor_col;

  modport source (output valid, cell_word, cursor_row, cursor_col, input ready);
  modport sink (input valid, cell_word, cursor_row, cursor_col, output ready);
endinterface

// ===== hw/rtl/ttw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ttw_fifo.sv =====
// short command queue between the front and back ends
`timescale 1ns / 1ps
module ttw_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ttw_pkg::cmd_t head,
  output logic          head_valid
);
  import ttw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/ttw_front.sv =====
// front end: takes request transactions and decodes them into commands
`timescale 1ns / 1ps
module ttw_front #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  ttw_req_if.sink       req,
  input  logic          full,
  output logic          push,
  output ttw_pkg::cmd_t push_cmd
);
  import ttw_pkg::*;

  logic in_range;

  assign in_range = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);
  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    push_cmd.char_code = req.char_code;
    push_cmd.row       = req.read_row;
    push_cmd.col       = req.read_col;
    unique case (kind_t'(req.kind))
      KIND_PUT:   push_cmd.op = (req.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      KIND_CLEAR: push_cmd.op = OP_CLEAR;
      KIND_READ:  push_cmd.op = in_range ? OP_READ : OP_NOP;
      default:    push_cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/ttw_back.sv =====
// back end: cursor, row ring offset, cell memory, blanking sweeps and result register
`timescale 1ns / 1ps
module ttw_back #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  input  logic             clk,
  input  logic             rst,
  input  ttw_pkg::cfg_wr_t cfg,
  input  ttw_pkg::cmd_t    head,
  input  logic             head_valid,
  output logic             pop,
  ttw_rsp_if.source        rsp
);
  import ttw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  state_t state, state_next;

  logic [RW-1:0]      row, row_next;
  logic [CW-1:0]      col, col_next;
  logic [RW-1:0]      offset, offset_next;
  logic [AW-1:0]      sweep_addr, sweep_addr_next;
  logic [AW-1:0]      sweep_last, sweep_last_next;
  logic [COLOR_W-1:0] fg, bg;

  logic                   rsp_valid, rsp_valid_next;
  logic [WORD_W-1:0]      cell_data, cell_data_next;
  logic [WORD_W-1:0]      rsp_word;
  logic [ROW_FIELD_W-1:0] rsp_row;
  logic [COL_FIELD_W-1:0] rsp_col;
  logic                   rsp_load;

  logic [RW-1:0]     row_sel;
  logic [CW-1:0]     col_sel;
  logic [RW:0]       phys_sum;
  logic [RW-1:0]     phys_row;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     base_addr;
  logic              last_row, last_col;
  logic              advance_row, scroll_req, sweep_done;
  logic [WORD_W-1:0] blank_word;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // logical row maps onto the physical ring of rows
  assign row_sel   = (head.op == OP_READ) ? head.row[RW-1:0] : row;
  assign col_sel   = (head.op == OP_READ) ? head.col[CW-1:0] : col;
  assign phys_sum  = {1'b0, row_sel} + {1'b0, offset};
  assign phys_row  = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                 : phys_sum[RW-1:0];
  assign cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
  assign base_addr = AW'(offset) * AW'(COLUMNS);

  assign last_row    = (row == RW'(ROWS - 1));
  assign last_col    = (col == CW'(COLUMNS - 1));
  assign advance_row = (head.op == OP_NEWLINE) || ((head.op == OP_PUT) && last_col);
  assign scroll_req  = advance_row && last_row;
  assign sweep_done  = (sweep_addr == sweep_last);
  assign blank_word  = {bg, fg, SPACE_CODE};
  assign rsp_load    = (state == ST_RESP) && (!rsp_valid || rsp.ready);

  ttw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op) inside
            OP_PUT, OP_NEWLINE: state_next = scroll_req ? ST_SWEEP : ST_RESP;
            OP_CLEAR:           state_next = ST_SWEEP;
            OP_READ:            state_next = ST_READ;
            default:            state_next = ST_RESP;
          endcase
        end
      end
      ST_READ:  state_next = ST_RESP;
      ST_SWEEP: begin
        if (sweep_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = sweep_addr;
    ram_wdata       = blank_word;
    row_next        = row;
    col_next        = col;
    offset_next     = offset;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    cell_data_next  = cell_data;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop            = 1'b1;
          cell_data_next = '0;
          unique case (head.op) inside
            OP_PUT, OP_NEWLINE: begin
              if (head.op == OP_PUT) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr;
                ram_wdata = {bg, fg, head.char_code};
                col_next  = col + CW'(1);
              end
              if (advance_row) begin
                col_next = '0;
                if (!last_row) begin
                  row_next = row + RW'(1);
                end
              end
              // the top physical row becomes the blank bottom row
              if (scroll_req) begin
                offset_next     = (offset == RW'(ROWS - 1)) ? '0 : offset + RW'(1);
                sweep_addr_next = base_addr;
                sweep_last_next = base_addr + AW'(COLUMNS - 1);
              end
            end
            OP_CLEAR: begin
              row_next        = '0;
              col_next        = '0;
              offset_next     = '0;
              sweep_addr_next = '0;
              sweep_last_next = AW'(CELLS - 1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cell_data_next = ram_rdata;
      end
      ST_SWEEP: begin
        ram_we          = 1'b1;
        sweep_addr_next = sweep_addr + AW'(1);
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      col       <= '0;
      offset    <= '0;
      fg        <= FG_RESET;
      bg        <= BG_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      offset    <= offset_next;
      rsp_valid <= rsp_valid_next;
      if (cfg.en) begin
        unique case (reg_index_t'(cfg.index))
          REG_FG:  fg <= cfg.data;
          REG_BG:  bg <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_addr <= sweep_addr_next;
    sweep_last <= sweep_last_next;
    cell_data  <= cell_data_next;
    if (rsp_load) begin
      rsp_word <= cell_data;
      rsp_row  <= ROW_FIELD_W'(row);
      rsp_col  <= COL_FIELD_W'(col);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.cell_word  = rsp_word;
  assign rsp.cursor_row = rsp_row;
  assign rsp.cursor_col = rsp_col;

endmodule

// ===== hw/rtl/text_terminal_writer.sv =====
// text terminal writer: put, clear and read over a ring of screen rows
// put, newline, unused kind and off-screen read pass from idle straight to the response
// state, a read passes the read state first, and a scrolling put or newline or a clear
// sweeps COLUMNS or ROWS * COLUMNS cells first, one cell a cycle on the cell memory
// write port; commands are popped only in idle, and requests queue meanwhile (two deep)
// reset restores cursor, row offset, colours and handshakes; cells hold no value until written
`timescale 1ns / 1ps
module text_terminal_writer #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  ttw_req_if.sink                         req,
  ttw_rsp_if.source                       rsp,
  input  logic                            wr_en,
  input  logic [ttw_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [ttw_pkg::COLOR_W-1:0]     wr_data
);
  import ttw_pkg::*;

  logic    push, full, pop, head_valid;
  cmd_t    push_cmd, head;
  cfg_wr_t cfg;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  ttw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req      (req),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ttw_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  ttw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ===== hw/rtl/ttw_checker.sv =====
// port-level checks of the text terminal writer, bound to the top level
`timescale 1ns / 1ps
module ttw_checker #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [ttw_pkg::WORD_W-1:0]      cell_word,
  input logic [ttw_pkg::ROW_FIELD_W-1:0] cursor_row,
  input logic [ttw_pkg::COL_FIELD_W-1:0] cursor_col
);
  import ttw_pkg::*;

  logic [3:0] pending;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_word) &&
      $stable(cursor_row) && $stable(cursor_col))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(cursor_row) < ROWS) && (int'(cursor_col) < COLUMNS))
    else $error("cursor outside the screen");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("result without a request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(pending) <= QUEUE_DEPTH + 2)
    else $error("more requests in flight than the design holds");

endmodule

bind text_terminal_writer ttw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cell_word  (rsp.cell_word),
  .cursor_row (rsp.cursor_row),
  .cursor_col (rsp.cursor_col)
);

// ===== bench/tb.sv =====
// self-checking testbench for the text terminal writer
`timescale 1ns / 1ps
module tb;
  import ttw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEMS       = 1900;
  localparam int PHASES      = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [CHAR_W-1:0]      ch;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
  } keystroke_t;

  typedef struct packed {
    logic [WORD_W-1:0]      word;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
  } screen_report_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [COLOR_W-1:0]     wr_data;

  ttw_req_if req ();
  ttw_rsp_if rsp ();

  text_terminal_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  keystroke_t     keystrokes[$];
  screen_report_t due_reports[$];
  keystroke_t     on_bus;

  // shadow copy of the screen, cursor and colours
  logic [WORD_W-1:0]  shadow_screen [CELLS];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] fg_nib;
  logic [COLOR_W-1:0] bg_nib;

  int     queued;
  int     fail_count;
  int     reports_seen;
  longint cycles;

  int burst_left;
  int gap_left;
  int hold_left;
  int hold_mark;
  int stall_mode;
  int mode_left;
  int pattern_tick;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [WORD_W-1:0] cell_of(logic [CHAR_W-1:0] ch);
    return {bg_nib, fg_nib, ch};
  endfunction

  function automatic screen_report_t emulate_terminal(keystroke_t k);
    screen_report_t r;
    r.word = '0;
    case (k.kind)
      KIND_PUT: begin
        if (k.ch == NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          shadow_screen[cur_row * COLUMNS + cur_col] = cell_of(k.ch);
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // past the bottom row: scroll up and blank the last row
        if (cur_row >= ROWS) begin
          cur_row = ROWS - 1;
          cur_col = 0;
          for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = cell_of(SPACE_CODE);
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = cell_of(SPACE_CODE);
        cur_row = 0;
        cur_col = 0;
      end
      KIND_READ: begin
        if (k.row < ROWS && k.col < COLUMNS) r.word = shadow_screen[k.row * COLUMNS + k.col];
      end
      default: ;
    endcase
    r.row = ROW_FIELD_W'(cur_row);
    r.col = COL_FIELD_W'(cur_col);
    return r;
  endfunction

  task automatic queue_key(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                           logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
    keystroke_t k;
    k.kind = kind;
    k.ch   = ch;
    k.row  = row;
    k.col  = col;
    keystrokes.push_back(k);
    queued++;
  endtask

  task automatic queue_read(bit off_screen);
    if (!off_screen) queue_key(KIND_READ, CHAR_W'($urandom),
                               ROW_FIELD_W'($urandom_range(0, ROWS - 1)),
                               COL_FIELD_W'($urandom_range(0, COLUMNS - 1)));
    else if ($urandom_range(0, 1)) queue_key(KIND_READ, CHAR_W'($urandom),
                                             ROW_FIELD_W'($urandom_range(ROWS, 31)),
                                             COL_FIELD_W'($urandom));
    else queue_key(KIND_READ, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                   COL_FIELD_W'($urandom_range(COLUMNS, 127)));
  endtask

  task automatic note_failure(string what, screen_report_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected word %h row %0d col %0d, got word %h row %0d col %0d",
               $time, what, want.word, want.row, want.col,
               rsp.cell_word, rsp.cursor_row, rsp.cursor_col);
  endtask

  // request driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req.valid && req.ready) due_reports.push_back(emulate_terminal(on_bus));
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (keystrokes.size() != 0) begin
          on_bus = keystrokes.pop_front();
          req.kind      <= on_bus.kind;
          req.char_code <= on_bus.ch;
          req.read_row  <= on_bus.row;
          req.read_col  <= on_bus.col;
          req.valid     <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response ready: changing stall patterns, plus long hold-offs to back the block up
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left    = 0;
      hold_mark    = -1;
      stall_mode   = 0;
      mode_left    = 0;
      pattern_tick = 0;
    end else begin
      if (hold_left == 0 && (reports_seen == 400 || reports_seen == 1200) &&
          hold_mark != reports_seen) begin
        hold_left = HOLD_CYCLES;
        hold_mark = reports_seen;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(50, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 9) < 6);
          2:       rsp.ready <= (pattern_tick % 3 != 0);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
        pattern_tick++;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    screen_report_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      reports_seen <= reports_seen + 1;
      if (due_reports.size() == 0) begin
        want = '0;
        note_failure("transaction with nothing due", want);
      end else begin
        want = due_reports.pop_front();
        if (rsp.cell_word !== want.word || rsp.cursor_row !== want.row ||
            rsp.cursor_col !== want.col)
          note_failure("mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    int                 seg;
    int                 len;
    logic [CHAR_W-1:0]  ch;

    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = REG_FG;
    wr_data       = '0;
    req.valid     = 1'b0;
    req.kind      = KIND_PUT;
    req.char_code = '0;
    req.read_row  = '0;
    req.read_col  = '0;
    rsp.ready     = 1'b0;
    fg_nib        = FG_RESET;
    bg_nib        = BG_RESET;
    cur_row       = 0;
    cur_col       = 0;
    queued        = 0;
    fail_count    = 0;
    reports_seen  = 0;
    cycles        = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      while (keystrokes.size() != 0 || req.valid || due_reports.size() != 0) @(negedge clk);
      case (p)
        0:       begin fg = 4'hF; bg = 4'h0; end
        1:       begin fg = 4'h0; bg = 4'hF; end
        2:       begin fg = 4'h0; bg = 4'h0; end
        3:       begin fg = 4'hF; bg = 4'hF; end
        default: begin fg = COLOR_W'($urandom); bg = COLOR_W'($urandom); end
      endcase
      @(posedge clk);
      wr_en    <= 1'b1;
      wr_index <= REG_FG;
      wr_data  <= fg;
      fg_nib = fg;
      @(posedge clk);
      wr_index <= REG_BG;
      wr_data  <= bg;
      bg_nib = bg;
      @(posedge clk);
      wr_en <= 1'b0;
      @(negedge clk);

      if (p == 0) begin
        // cells are only readable once written, so the first command is a clear
        queue_key(KIND_CLEAR, 8'h5A, 5'd31, 7'd127);
        queue_key(KIND_READ, 8'hFF, ROW_FIELD_W'(ROWS - 1), COL_FIELD_W'(COLUMNS - 1));
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd0);
        queue_key(KIND_PUT, 8'h41, 5'd31, 7'd127);
        queue_key(KIND_PUT, 8'hFF, 5'd0, 7'd0);
        queue_key(KIND_PUT, 8'h80, 5'd0, 7'd0);
        queue_key(KIND_PUT, 8'h00, 5'd0, 7'd0);
        queue_key(KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        queue_key(KIND_PUT, NEWLINE_CODE, 5'd31, 7'd127);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd0);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd1);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd2);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd3);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd4);
        // reads off the screen and the unused kind change nothing
        queue_key(KIND_READ, 8'h00, ROW_FIELD_W'(ROWS), 7'd0);
        queue_key(KIND_READ, 8'h00, 5'd0, COL_FIELD_W'(COLUMNS));
        queue_key(KIND_READ, 8'hFF, 5'd31, 7'd127);
        queue_key(KIND_UNUSED, 8'hFF, 5'd31, 7'd127);
        queue_key(KIND_UNUSED, NEWLINE_CODE, 5'd0, 7'd0);
        queue_key(KIND_READ, 8'h00, 5'd2, 7'd0);
        queue_key(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        queue_key(KIND_READ, 8'h00, 5'd0, 7'd0);
      end

      while (queued < (p + 1) * ITEMS / PHASES) begin
        seg = $urandom_range(0, 99);
        if (seg < 50) begin
          // a line of text, now and then long enough to wrap
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 40);
          for (int i = 0; i < len; i++) begin
            ch = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(0, 255))
                                             : CHAR_W'($urandom_range(8'h20, 8'h7E));
            queue_key(KIND_PUT, ch, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
          end
          if ($urandom_range(0, 4) != 0)
            queue_key(KIND_PUT, NEWLINE_CODE, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
        end else if (seg < 60) begin
          // run of newlines to reach the bottom row and scroll
          len = $urandom_range(1, 30);
          for (int i = 0; i < len; i++)
            queue_key(KIND_PUT, NEWLINE_CODE, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
        end else if (seg < 93) begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) queue_read($urandom_range(0, 6) == 0);
        end else if (seg < 98) begin
          queue_key(KIND_UNUSED, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                    COL_FIELD_W'($urandom));
        end else begin
          queue_key(KIND_CLEAR, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                    COL_FIELD_W'($urandom));
        end
      end
    end

    while (keystrokes.size() != 0 || req.valid || due_reports.size() != 0) @(negedge clk);
    repeat (CELLS + 4) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
